@@ src/gtd_pkg.sv @@
// Shared types and constants for the GUID text decoder.
package gtd_pkg;

  // One character of the GUID string.
  typedef struct packed {
    logic [7:0] text_char;
    logic       is_last;
  } char_item_t;

  // One decoded GUID.
  typedef struct packed {
    logic        guid_ok;
    logic [31:0] part_one;
    logic [15:0] part_two;
    logic [15:0] part_three;
    logic [63:0] tail_bytes;
  } result_item_t;

  // What the classifier says about one character at its position.
  typedef struct packed {
    logic       is_hex;
    logic       is_dash;
    logic       sep_pos;
    logic       past_end;
    logic [3:0] nibble;
  } char_class_t;

  localparam int unsigned POS_W = 6;

  localparam logic [POS_W-1:0] TEXT_LEN = 6'd36;
  localparam logic [POS_W-1:0] LAST_POS = 6'd35;
  localparam logic [POS_W-1:0] POS_SAT  = 6'd37;

  localparam logic [POS_W-1:0] SEP_POS_A = 6'd8;
  localparam logic [POS_W-1:0] SEP_POS_B = 6'd13;
  localparam logic [POS_W-1:0] SEP_POS_C = 6'd18;
  localparam logic [POS_W-1:0] SEP_POS_D = 6'd23;

  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_F  = 8'h46;
  localparam logic [7:0] ALPHA_BASE = 8'd10;

endpackage

@@ src/gtd_char_class.sv @@
// Character classifier: hex decode, dash detect and position checks.
module gtd_char_class (
  input  logic [7:0]                text_char,
  input  logic [gtd_pkg::POS_W-1:0] char_position,
  output gtd_pkg::char_class_t      cls
);

  logic       is_digit;
  logic       is_lower;
  logic       is_upper;
  logic [7:0] nib_wide;

  assign is_digit = (text_char >= gtd_pkg::CHAR_ZERO) && (text_char <= gtd_pkg::CHAR_NINE);
  assign is_lower = (text_char >= gtd_pkg::CHAR_LC_A) && (text_char <= gtd_pkg::CHAR_LC_F);
  assign is_upper = (text_char >= gtd_pkg::CHAR_UC_A) && (text_char <= gtd_pkg::CHAR_UC_F);

  always_comb begin
    if (is_digit) begin
      nib_wide = text_char - gtd_pkg::CHAR_ZERO;
    end else if (is_lower) begin
      nib_wide = text_char - gtd_pkg::CHAR_LC_A + gtd_pkg::ALPHA_BASE;
    end else if (is_upper) begin
      nib_wide = text_char - gtd_pkg::CHAR_UC_A + gtd_pkg::ALPHA_BASE;
    end else begin
      nib_wide = 8'd0;
    end
  end

  assign cls.is_hex   = is_digit || is_lower || is_upper;
  assign cls.is_dash  = (text_char == gtd_pkg::CHAR_DASH);
  assign cls.nibble   = nib_wide[3:0];
  assign cls.past_end = (char_position >= gtd_pkg::TEXT_LEN);
  assign cls.sep_pos  = (char_position == gtd_pkg::SEP_POS_A) ||
                        (char_position == gtd_pkg::SEP_POS_B) ||
                        (char_position == gtd_pkg::SEP_POS_C) ||
                        (char_position == gtd_pkg::SEP_POS_D);

endmodule

@@ src/gtd_parse_state.sv @@
// Parse state: position counter, error flag and 128-bit digit accumulator.
module gtd_parse_state (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      is_last,
  input  gtd_pkg::char_class_t      cls,
  output logic [gtd_pkg::POS_W-1:0] char_position,
  output gtd_pkg::result_item_t     result
);

  logic                      bad_seen;
  logic [63:0]               upper_digits;
  logic [63:0]               lower_digits;
  logic                      bad_seen_next;
  logic [63:0]               upper_digits_next;
  logic [63:0]               lower_digits_next;
  logic [gtd_pkg::POS_W-1:0] char_position_next;
  logic                      ok;

  always_comb begin
    bad_seen_next     = bad_seen;
    upper_digits_next = upper_digits;
    lower_digits_next = lower_digits;
    if (cls.past_end) begin
      bad_seen_next = 1'b1;
    end else if (cls.sep_pos) begin
      // A hex digit in a separator slot is tolerated but not stored.
      if (!cls.is_hex && !cls.is_dash) begin
        bad_seen_next = 1'b1;
      end
    end else if (cls.is_hex) begin
      upper_digits_next = {upper_digits[59:0], lower_digits[63:60]};
      lower_digits_next = {lower_digits[59:0], cls.nibble};
    end else begin
      bad_seen_next = 1'b1;
    end

    if (char_position < gtd_pkg::POS_SAT) begin
      char_position_next = char_position + 1'b1;
    end else begin
      char_position_next = char_position;
    end
  end

  assign ok = !bad_seen_next && (char_position == gtd_pkg::LAST_POS);

  assign result.guid_ok    = ok;
  assign result.part_one   = ok ? upper_digits_next[63:32] : 32'd0;
  assign result.part_two   = ok ? upper_digits_next[31:16] : 16'd0;
  assign result.part_three = ok ? upper_digits_next[15:0]  : 16'd0;
  assign result.tail_bytes = ok ? lower_digits_next        : 64'd0;

  always_ff @(posedge clk) begin
    if (rst || (advance && is_last)) begin
      char_position <= '0;
      bad_seen      <= 1'b0;
      upper_digits  <= 64'd0;
      lower_digits  <= 64'd0;
    end else if (advance) begin
      char_position <= char_position_next;
      bad_seen      <= bad_seen_next;
      upper_digits  <= upper_digits_next;
      lower_digits  <= lower_digits_next;
    end
  end

endmodule

@@ src/guid_text_decoder.sv @@
// Top level of the GUID text decoder: input register, parser and result register.
//
// This block parses a GUID written as text in the 8-4-4-4-12 form, one ASCII
// character per item on the char channel, with is_last set on the final
// character. Every position must hold a hex digit in either case; the four
// separator positions may hold a dash instead (a hex digit there is accepted
// and ignored). On the item marked last the block delivers one result item
// with guid_ok set when the string was exactly 36 characters and every
// character was allowed, and the 32 digits packed into part_one, part_two,
// part_three and tail_bytes; all fields but guid_ok are zero when the string
// is malformed. Items without the last mark produce no result. The parser
// then returns to its start state for the next string. The block takes one
// character every clock cycle unless a full result register is not taken: a
// character is captured in the input register, and once the result register
// is free it is classified and shifted into the 128-bit accumulator while its
// result, if any, is loaded into the result register at the same clock edge.
// A full result register that is not taken holds the pipeline; the char
// channel stays ready as long as the input register is empty or can move
// forward.
module guid_text_decoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_ready,
  input  gtd_pkg::char_item_t   char_item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output gtd_pkg::result_item_t result_item
);

  // Input register stage.
  logic                      hold_valid;
  gtd_pkg::char_item_t       hold_item;

  logic                      out_free;
  logic                      advance;
  logic [gtd_pkg::POS_W-1:0] char_position;
  gtd_pkg::char_class_t      cls;
  gtd_pkg::result_item_t     result;

  // The result register can take a new value when it is empty or being read.
  assign out_free   = !result_valid || result_ready;
  // The held character is processed when its result (if any) has a place to go.
  assign advance    = hold_valid && out_free;
  assign char_ready = !hold_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (char_ready) begin
      hold_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      hold_item <= char_item;
    end
  end

  gtd_char_class u_class (
    .text_char     (hold_item.text_char),
    .char_position (char_position),
    .cls           (cls)
  );

  gtd_parse_state u_state (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .is_last       (hold_item.is_last),
    .cls           (cls),
    .char_position (char_position),
    .result        (result)
  );

  // Result register: loaded only by a character that carries the last mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= advance && hold_item.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_item.is_last) begin
      result_item <= result;
    end
  end

endmodule

@@ src/gtd_checker.sv @@
// Port-level checks for the GUID text decoder and their bind.
module gtd_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  char_valid,
  input logic                  char_ready,
  input gtd_pkg::char_item_t   char_item,
  input logic                  result_valid,
  input logic                  result_ready,
  input gtd_pkg::result_item_t result_item
);

  // A result that is not taken stays put.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_item))
    else $error("stalled result item changed or dropped");

  // A malformed string never leaks digits.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.guid_ok |->
      result_item.part_one == 32'd0 && result_item.part_two == 16'd0 &&
      result_item.part_three == 16'd0 && result_item.tail_bytes == 64'd0)
    else $error("invalid GUID carries nonzero fields");

  // The char side is held off only by a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    !char_ready |-> result_valid && !result_ready)
    else $error("char channel stalled without result back-pressure");

  // Reset empties the result register.
  assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // A char item that waits keeps its payload until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_ready |=> char_valid && $stable(char_item))
    else $error("waiting char item changed or dropped");

endmodule

bind guid_text_decoder gtd_checker u_gtd_checker (.*);

@@ tb/guid_text_decoder_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the GUID text decoder, with its own decoder model.
module guid_text_decoder_test;

  // A run ends in failure once this many cycles pass with no handshake on
  // either channel. The slowest correct stretch is a sender gap plus a
  // receiver stall plus the passage through the pipeline, so this leaves a
  // wide margin.
  localparam int unsigned QUIET_LIMIT = 500;
  // Cycles to keep watching after the last expected result, so that any
  // stray result still in the two-stage pipeline would be caught.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned RANDOM_CHARS = 440;
  localparam int unsigned STEADY_CHARS = 300;

  // How the hex letters of a generated GUID are written.
  typedef enum logic [1:0] {CASE_LOWER, CASE_UPPER, CASE_MIXED} letter_case_t;
  // What goes into the four separator positions of a generated GUID.
  typedef enum logic [1:0] {SEP_DASH, SEP_DIGIT, SEP_EITHER} sep_style_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  char_valid;
  logic                  char_ready;
  gtd_pkg::char_item_t   char_item;
  logic                  result_valid;
  logic                  result_ready;
  gtd_pkg::result_item_t result_item;

  guid_text_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_item    (char_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model state of the parser: position counter, error flag and the 128-bit
  // digit accumulator, all cleared by reset and after each last character.
  logic [gtd_pkg::POS_W-1:0] dec_pos;
  logic                      dec_bad;
  logic [127:0]              dec_digits;

  gtd_pkg::result_item_t guid_expect_q[$];   // decoded GUIDs still owed by the block
  logic [7:0]            text_buf[$];        // characters of the string being built
  int unsigned           mismatch_count;
  int unsigned           chars_sent;
  int unsigned           quiet_cycles;
  int unsigned           stall_left;
  bit                    idle_enable;
  gtd_pkg::result_item_t want;

  // ---------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------

  function automatic bit char_nibble(input logic [7:0] c, output logic [3:0] nib);
    nib = 4'h0;
    if (c >= gtd_pkg::CHAR_ZERO && c <= gtd_pkg::CHAR_NINE) begin
      nib = 4'(c - gtd_pkg::CHAR_ZERO);
      return 1'b1;
    end
    if (c >= gtd_pkg::CHAR_LC_A && c <= gtd_pkg::CHAR_LC_F) begin
      nib = 4'(c - gtd_pkg::CHAR_LC_A + gtd_pkg::ALPHA_BASE);
      return 1'b1;
    end
    if (c >= gtd_pkg::CHAR_UC_A && c <= gtd_pkg::CHAR_UC_F) begin
      nib = 4'(c - gtd_pkg::CHAR_UC_A + gtd_pkg::ALPHA_BASE);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit sep_position(input logic [gtd_pkg::POS_W-1:0] p);
    return p == gtd_pkg::SEP_POS_A || p == gtd_pkg::SEP_POS_B ||
           p == gtd_pkg::SEP_POS_C || p == gtd_pkg::SEP_POS_D;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) begin
      return gtd_pkg::CHAR_ZERO + {4'h0, nib};
    end
    return (upper ? gtd_pkg::CHAR_UC_A : gtd_pkg::CHAR_LC_A) + {4'h0, nib} -
           gtd_pkg::ALPHA_BASE;
  endfunction

  task automatic clear_decoder();
    dec_pos    = '0;
    dec_bad    = 1'b0;
    dec_digits = '0;
  endtask

  // Advances the model by one accepted character. A character marked last
  // closes the string and yields the decoded GUID, or all zero fields with
  // guid_ok low when the string was malformed in any way.
  task automatic decode_char(input gtd_pkg::char_item_t it, output bit done,
                             output gtd_pkg::result_item_t res);
    logic [3:0]                nib;
    bit                        hex;
    bit                        ok;
    logic [gtd_pkg::POS_W-1:0] pos;
    pos  = dec_pos;
    hex  = char_nibble(it.text_char, nib);
    done = 1'b0;
    res  = '0;
    if (pos >= gtd_pkg::TEXT_LEN) begin
      // Anything beyond the 36th character spoils the string.
      dec_bad = 1'b1;
    end else if (sep_position(pos)) begin
      // A separator slot takes a dash or a hex digit; the digit is dropped.
      if (!hex && it.text_char != gtd_pkg::CHAR_DASH) begin
        dec_bad = 1'b1;
      end
    end else if (hex) begin
      dec_digits = {dec_digits[123:0], nib};
    end else begin
      dec_bad = 1'b1;
    end
    if (dec_pos < gtd_pkg::POS_SAT) begin
      dec_pos = dec_pos + 1'b1;
    end
    if (it.is_last) begin
      ok   = !dec_bad && pos == gtd_pkg::LAST_POS;
      done = 1'b1;
      res.guid_ok = ok;
      if (ok) begin
        res.part_one   = dec_digits[127:96];
        res.part_two   = dec_digits[95:80];
        res.part_three = dec_digits[79:64];
        res.tail_bytes = dec_digits[63:0];
      end
      clear_decoder();
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Offers one character and returns at the edge where it is accepted. The
  // valid line changes at most once per edge: it either drops for an idle
  // burst or carries the new character, never both.
  task automatic send_char(input logic [7:0] c, input bit last);
    gtd_pkg::char_item_t   it;
    bit                    done;
    gtd_pkg::result_item_t res;
    it.text_char = c;
    it.is_last   = last;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_item  <= it;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    decode_char(it, done, res);
    if (done) begin
      guid_expect_q.push_back(res);
    end
    chars_sent++;
  endtask

  // Sends the built string with the last mark on its final character.
  task automatic send_text();
    logic [7:0] c;
    for (int i = 0; i < text_buf.size(); i++) begin
      c = text_buf[i];
      send_char(c, i == text_buf.size() - 1);
    end
  endtask

  // Builds a well-formed 36-character GUID from the given 32 digits.
  task automatic build_guid(input logic [127:0] digits, input letter_case_t lc,
                            input sep_style_t sep);
    int         d;
    bit         upper;
    logic [3:0] nib;
    text_buf.delete();
    d = 0;
    for (int p = 0; p < gtd_pkg::TEXT_LEN; p++) begin
      upper = (lc == CASE_UPPER) || (lc == CASE_MIXED && $urandom_range(0, 1) == 1);
      if (sep_position(p[gtd_pkg::POS_W-1:0])) begin
        nib = 4'($urandom);
        if (sep == SEP_DASH || (sep == SEP_EITHER && $urandom_range(0, 1) == 0)) begin
          text_buf.push_back(gtd_pkg::CHAR_DASH);
        end else begin
          text_buf.push_back(hex_char(nib, upper));
        end
      end else begin
        text_buf.push_back(hex_char(digits[127 - 4 * d -: 4], upper));
        d++;
      end
    end
  endtask

  function automatic logic [127:0] random_digits();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Random digit position, never one of the separator slots.
  function automatic int digit_position();
    int p;
    p = $urandom_range(0, gtd_pkg::TEXT_LEN - 1);
    if (sep_position(p[gtd_pkg::POS_W-1:0])) begin
      p++;
    end
    return p;
  endfunction

  // One random string: mostly well-formed GUIDs with random content, the
  // rest with a replaced byte, a wrong length, or plain noise.
  task automatic send_random_string();
    int kind;
    int len;
    kind = $urandom_range(0, 9);
    build_guid(random_digits(), CASE_MIXED, SEP_EITHER);
    case (kind)
      7: begin
        text_buf[$urandom_range(0, gtd_pkg::TEXT_LEN - 1)] = 8'($urandom);
      end
      8: begin
        if ($urandom_range(0, 1) == 0) begin
          len = $urandom_range(1, gtd_pkg::TEXT_LEN - 1);
          while (text_buf.size() > len) void'(text_buf.pop_back());
        end else begin
          repeat ($urandom_range(1, 10)) text_buf.push_back(8'($urandom));
        end
      end
      9: begin
        text_buf.delete();
        repeat ($urandom_range(1, 45)) text_buf.push_back(8'($urandom));
      end
      default: begin
      end
    endcase
    send_text();
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Hand-picked strings: digit extremes in both cases, separator slots
  // holding digits, wrong lengths on either side, and bytes just outside
  // each accepted character range.
  task automatic test_directed();
    logic [7:0] edge_chars[6];
    edge_chars = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

    build_guid('0, CASE_LOWER, SEP_DASH);
    send_text();
    build_guid('1, CASE_UPPER, SEP_DASH);
    send_text();
    build_guid('1, CASE_LOWER, SEP_DIGIT);
    send_text();
    build_guid(128'h0123456789abcdef_fedcba9876543210, CASE_MIXED, SEP_EITHER);
    send_text();

    // One character short.
    build_guid(random_digits(), CASE_MIXED, SEP_DASH);
    void'(text_buf.pop_back());
    send_text();
    // One character too many.
    build_guid(random_digits(), CASE_LOWER, SEP_DASH);
    text_buf.push_back(gtd_pkg::CHAR_ZERO);
    send_text();
    // Far too long, so the position counter has to hold at its ceiling.
    build_guid(random_digits(), CASE_UPPER, SEP_DASH);
    repeat (40) text_buf.push_back(gtd_pkg::CHAR_LC_A);
    send_text();
    // A lone character marked last.
    text_buf.delete();
    text_buf.push_back(gtd_pkg::CHAR_ZERO);
    send_text();

    // NUL at the start, an all-ones byte in a digit slot, a letter past 'f'
    // in a separator slot, a dash in a digit slot, and a bad final character.
    build_guid(random_digits(), CASE_MIXED, SEP_DASH);
    text_buf[0] = 8'h00;
    send_text();
    build_guid(random_digits(), CASE_MIXED, SEP_DASH);
    text_buf[digit_position()] = 8'hFF;
    send_text();
    build_guid(random_digits(), CASE_MIXED, SEP_DASH);
    text_buf[gtd_pkg::SEP_POS_B] = 8'h67;
    send_text();
    build_guid(random_digits(), CASE_MIXED, SEP_DASH);
    text_buf[5] = gtd_pkg::CHAR_DASH;
    send_text();
    build_guid(random_digits(), CASE_MIXED, SEP_DASH);
    text_buf[gtd_pkg::LAST_POS] = 8'h7A;
    send_text();
    // The neighbors of the dash in a separator slot.
    build_guid(random_digits(), CASE_MIXED, SEP_DASH);
    text_buf[gtd_pkg::SEP_POS_A] = 8'h2E;
    send_text();
    build_guid(random_digits(), CASE_MIXED, SEP_DASH);
    text_buf[gtd_pkg::SEP_POS_D] = 8'h2C;
    send_text();

    // Bytes right next to '0'..'9', 'A'..'F' and 'a'..'f' in digit slots.
    foreach (edge_chars[i]) begin
      build_guid(random_digits(), CASE_MIXED, SEP_EITHER);
      text_buf[digit_position()] = edge_chars[i];
      send_text();
    end
  endtask

  // Bulk random strings with idle bursts on both channels.
  task automatic test_random();
    int unsigned stop_at;
    stop_at = chars_sent + RANDOM_CHARS;
    while (chars_sent < stop_at) send_random_string();
  endtask

  // Closing stretch at full rate: a character offered and a result taken on
  // every cycle, so the pipeline runs back to back across string borders.
  task automatic test_back_to_back();
    int unsigned stop_at;
    idle_enable = 1'b0;
    stop_at = chars_sent + STEADY_CHARS;
    while (chars_sent < stop_at) send_random_string();
  endtask

  // ---------------------------------------------------------------------
  // Result side: ready with random stall bursts, and the checker
  // ---------------------------------------------------------------------

  task automatic flag_error(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Every result taken is matched against the oldest owed GUID.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (guid_expect_q.size() == 0) begin
        flag_error($sformatf("result with none expected: ok=%b %h %h %h %h",
                             result_item.guid_ok, result_item.part_one,
                             result_item.part_two, result_item.part_three,
                             result_item.tail_bytes));
      end else begin
        want = guid_expect_q.pop_front();
        if (result_item !== want) begin
          flag_error($sformatf({"result mismatch: expected ok=%b %h %h %h %h, ",
                                "got ok=%b %h %h %h %h"},
                               want.guid_ok, want.part_one, want.part_two,
                               want.part_three, want.tail_bytes,
                               result_item.guid_ok, result_item.part_one,
                               result_item.part_two, result_item.part_three,
                               result_item.tail_bytes));
        end
      end
    end
  end

  // Watchdog: a hang on either channel ends the run.
  always @(posedge clk) begin
    if (!rst) begin
      if ((char_valid && char_ready) || (result_valid && result_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("guid_text_decoder_test: done, errors");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    rst            = 1'b1;
    char_valid     = 1'b0;
    char_item      = '0;
    result_ready   = 1'b0;
    stall_left     = 0;
    quiet_cycles   = 0;
    mismatch_count = 0;
    chars_sent     = 0;
    idle_enable    = 1'b1;
    clear_decoder();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random();
    test_back_to_back();

    char_valid <= 1'b0;
    while (guid_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("guid_text_decoder_test: done, clean");
    end else begin
      $display("guid_text_decoder_test: done, errors");
    end
    $finish;
  end

endmodule
